FILE: sv/srb_pkg.sv
// Package: shared types, command and status codes for the suspend readiness barrier.
package srb_pkg;

  localparam int MAX_DELAYS  = 16;
  localparam int SLOT_BITS   = 4;
  localparam int CLIENT_BITS = 8;

  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_UNREGISTER = 3'd1;
  localparam logic [2:0] CMD_ACK        = 3'd2;
  localparam logic [2:0] CMD_CLIENT_GONE = 3'd3;
  localparam logic [2:0] CMD_PREPARE    = 3'd4;
  localparam logic [2:0] CMD_FINISH     = 3'd5;
  localparam logic [2:0] CMD_TICK       = 3'd6;
  localparam logic [2:0] CMD_RESERVED   = 3'd7;  // no operation, status ok

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_UNKNOWN       = 3'd1;
  localparam logic [2:0] ST_WRONG_SUSPEND = 3'd2;
  localparam logic [2:0] ST_NOT_AWAITED   = 3'd3;
  localparam logic [2:0] ST_FULL          = 3'd4;

  localparam logic [1:0] CFG_MAX_WAIT  = 2'd0;
  localparam logic [1:0] CFG_DARK_MIN  = 2'd1;
  localparam logic [1:0] CFG_FIRST_ID  = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] dly_ident;
    logic [31:0] timeout_ticks;
    logic [7:0]  client_id;
    logic [31:0] susp_num;
    logic        dark_resume;
  } srb_in_t;

  typedef struct packed {
    logic        ready_notify;
    logic [31:0] ready_susp_num;
    logic [31:0] assigned_ident;
    logic [2:0]  status;
    logic        ready_now;
  } srb_out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture the input item
    logic scan;     // run the table scan (max timeout)
    logic execute;  // apply the command
    logic emit;     // present the result
  } srb_ctl_t;

endpackage

FILE: sv/srb_ctrl.sv
// Controller: sequences load, timeout scan, execute and result strobe.
module srb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output srb_pkg::srb_ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_SCAN;
      S_SCAN: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign ctl.load    = (state_r == S_IDLE) && start;
  assign ctl.scan    = (state_r == S_SCAN);
  assign ctl.execute = (state_r == S_EXEC);
  assign ctl.emit    = (state_r == S_EMIT);

endmodule

FILE: sv/srb_datapath.sv
// Datapath: delay table, identifier counter, suspend timers and result register.
module srb_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  srb_pkg::srb_ctl_t ctl,
  input  srb_pkg::srb_in_t  in_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_data,
  output srb_pkg::srb_out_t res,
  output logic              res_valid
);

  localparam int N = srb_pkg::MAX_DELAYS;
  localparam int NODES = 2 * N - 1;

  logic [31:0] max_wait_r, dark_min_r;
  srb_pkg::srb_in_t item_r;

  logic [N-1:0] valid_r, awaited_r;
  logic [31:0]  ident_r   [N];
  logic [srb_pkg::CLIENT_BITS-1:0] owner_r [N];
  logic [31:0]  timeout_r [N];
  logic [31:0]  next_id_r, cur_susp_r;
  logic [31:0]  max_left_r, min_left_r;
  logic         max_on_r, min_on_r;

  // scan results (registered in the cycle before execute)
  logic [31:0]  longest_r;
  logic [N-1:0] id_hit_r, owner_hit_r;
  logic         susp_eq_r;

  srb_pkg::srb_out_t res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_wait_r <= 32'd10000;
      dark_min_r <= 32'd500;
    end else if (cfg_we) begin
      if (cfg_idx == srb_pkg::CFG_MAX_WAIT) max_wait_r <= cfg_data;
      if (cfg_idx == srb_pkg::CFG_DARK_MIN) dark_min_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) item_r <= in_item;
  end

  // scan: per-slot compares and max timeout via a tree
  logic [31:0]  longest_c;
  logic [N-1:0] id_hit_c, owner_hit_c;
  logic [31:0]  tmo_node [NODES];
  always_comb begin
    for (int i = 0; i < N; i++) begin
      id_hit_c[i]    = valid_r[i] && (ident_r[i] == item_r.dly_ident);
      owner_hit_c[i] = valid_r[i] &&
                       (owner_r[i] == item_r.client_id[srb_pkg::CLIENT_BITS-1:0]);
      tmo_node[N-1+i] = valid_r[i] ? timeout_r[i] : 32'd0;
    end
    for (int k = N - 2; k >= 0; k--) begin
      tmo_node[k] = (tmo_node[2*k+1] > tmo_node[2*k+2]) ? tmo_node[2*k+1] : tmo_node[2*k+2];
    end
    longest_c = tmo_node[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      longest_r   <= (longest_c > max_wait_r) ? max_wait_r : longest_c;
      id_hit_r    <= id_hit_c;
      owner_hit_r <= owner_hit_c;
      susp_eq_r   <= (item_r.susp_num == cur_susp_r);
    end
  end

  // lowest-set selection helper
  function automatic logic [N-1:0] lowest(input logic [N-1:0] v);
    return v & (~v + 1'b1);
  endfunction

  // execute
  logic [N-1:0] valid_nxt, awaited_nxt, free_sel, id_sel, ack_sel;
  logic [31:0]  next_id_nxt, cur_susp_nxt, max_left_nxt, min_left_nxt, assigned;
  logic         max_on_nxt, min_on_nxt, notify;
  logic [2:0]   status;

  always_comb begin
    valid_nxt    = valid_r;
    awaited_nxt  = awaited_r;
    next_id_nxt  = next_id_r;
    cur_susp_nxt = cur_susp_r;
    max_left_nxt = max_left_r;
    min_left_nxt = min_left_r;
    max_on_nxt   = max_on_r;
    min_on_nxt   = min_on_r;
    notify       = 1'b0;
    assigned     = '0;
    status       = srb_pkg::ST_OK;
    free_sel     = lowest(~valid_r);
    id_sel       = lowest(id_hit_r);
    ack_sel      = lowest(id_hit_r & awaited_r);
    case (item_r.cmd)
      srb_pkg::CMD_REGISTER: begin
        if (&valid_r) status = srb_pkg::ST_FULL;
        else begin
          valid_nxt   = valid_r | free_sel;
          awaited_nxt = awaited_r & ~free_sel;
          assigned    = next_id_r;
          next_id_nxt = next_id_r + 32'd1;
        end
      end
      srb_pkg::CMD_UNREGISTER: begin
        if (id_hit_r == '0) status = srb_pkg::ST_UNKNOWN;
        else begin
          valid_nxt   = valid_r & ~id_sel;
          awaited_nxt = awaited_r & ~id_sel;
          if ((awaited_r & id_sel) != '0 && awaited_nxt == '0 && !min_on_r) begin
            max_on_nxt = 1'b0;
            notify     = 1'b1;
          end
        end
      end
      srb_pkg::CMD_ACK: begin
        if (!susp_eq_r) status = srb_pkg::ST_WRONG_SUSPEND;
        else if (ack_sel == '0) status = srb_pkg::ST_NOT_AWAITED;
        else begin
          awaited_nxt = awaited_r & ~ack_sel;
          if (awaited_nxt == '0 && !min_on_r) begin
            max_on_nxt = 1'b0;
            notify     = 1'b1;
          end
        end
      end
      srb_pkg::CMD_CLIENT_GONE: begin
        valid_nxt   = valid_r & ~owner_hit_r;
        awaited_nxt = awaited_r & ~owner_hit_r;
        if ((awaited_r & owner_hit_r) != '0 && awaited_nxt == '0 && !min_on_r) begin
          max_on_nxt = 1'b0;
          notify     = 1'b1;
        end
      end
      srb_pkg::CMD_PREPARE: begin
        cur_susp_nxt = item_r.susp_num;
        awaited_nxt  = valid_r;
        if (item_r.dark_resume) begin
          min_on_nxt   = 1'b1;
          min_left_nxt = dark_min_r;
        end else if (valid_r == '0) notify = 1'b1;
        if (valid_r != '0) begin
          max_on_nxt   = 1'b1;
          max_left_nxt = longest_r;
        end
      end
      srb_pkg::CMD_FINISH: begin
        if (!susp_eq_r) status = srb_pkg::ST_WRONG_SUSPEND;
        else begin
          max_on_nxt  = 1'b0;
          min_on_nxt  = 1'b0;
          awaited_nxt = '0;
        end
      end
      srb_pkg::CMD_TICK: begin
        if (min_on_r) begin
          if (min_left_r <= 32'd1) begin
            min_left_nxt = '0;
            min_on_nxt   = 1'b0;
            if (awaited_r == '0) begin
              max_on_nxt = 1'b0;
              notify     = 1'b1;
            end
          end else min_left_nxt = min_left_r - 32'd1;
        end
        if (max_on_nxt) begin
          if (max_left_r <= 32'd1) begin
            max_left_nxt = '0;
            max_on_nxt   = 1'b0;
            awaited_nxt  = '0;
            notify       = 1'b1;
          end else max_left_nxt = max_left_r - 32'd1;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      awaited_r  <= '0;
      next_id_r  <= 32'd1;
      cur_susp_r <= '0;
      max_left_r <= '0;
      min_left_r <= '0;
      max_on_r   <= 1'b0;
      min_on_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == srb_pkg::CFG_FIRST_ID) next_id_r <= cfg_data;
      if (ctl.execute) begin
        valid_r    <= valid_nxt;
        awaited_r  <= awaited_nxt;
        next_id_r  <= next_id_nxt;
        cur_susp_r <= cur_susp_nxt;
        max_left_r <= max_left_nxt;
        min_left_r <= min_left_nxt;
        max_on_r   <= max_on_nxt;
        min_on_r   <= min_on_nxt;
      end
    end
  end

  // slot payload write on register
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (ctl.execute && item_r.cmd == srb_pkg::CMD_REGISTER && !(&valid_r) &&
          free_sel[i]) begin
        ident_r[i]   <= next_id_r;
        owner_r[i]   <= item_r.client_id[srb_pkg::CLIENT_BITS-1:0];
        timeout_r[i] <= item_r.timeout_ticks;
      end
    end
  end

  // result register; ready_now is derived from the state committed at execute
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      res_r.ready_notify   <= notify;
      res_r.ready_susp_num <= cur_susp_nxt;
      res_r.assigned_ident <= assigned;
      res_r.status         <= status;
      res_r.ready_now      <= (awaited_nxt == '0) && !min_on_nxt;
    end
  end

  // result strobe during the controller's emit cycle
  assign res       = res_r;
  assign res_valid = ctl.emit;

endmodule

FILE: sv/suspend_readiness_barrier_top.sv
// Top level: suspend readiness barrier, controller plus datapath.
// Usage:
//   Input channel: drive in_item and pulse start while busy is low; the
//   command is taken at that edge and busy rises for the following cycles.
//   Result channel: out_valid is high for exactly one cycle carrying
//   out_item; the receiver cannot stall and must take it in that cycle.
//   Every command yields exactly one result.
//   Sequence: after the accepting edge the controller steps through the
//   table scan, execute and emit states, and out_valid is high in emit;
//   one command occupies the block through load, table scan, execute and
//   emit, and a new command is taken only once busy is low again, set by
//   the controller sequence around the single 16-slot table scan.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high; write only while busy is low. Index 2 also reloads the
//   next identifier.
//   Reset (rst_n low, synchronous): table empty, timers off, suspend number
//   zero, registers at their default values.
module suspend_readiness_barrier_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  srb_pkg::srb_in_t  in_item,
  output logic              out_valid,
  output srb_pkg::srb_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  srb_pkg::srb_ctl_t ctl;

  assign cfg_ready = 1'b1;

  srb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  srb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_item),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_data  (cfg_data),
    .res       (out_item),
    .res_valid (out_valid)
  );

endmodule

FILE: verif/suspend_readiness_barrier_top_tb.sv
// Testbench: suspend readiness barrier, checked against an in-bench predictor.
module suspend_readiness_barrier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  srb_pkg::srb_in_t in_item = '0;
  logic out_valid;
  srb_pkg::srb_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  suspend_readiness_barrier_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic        tbl_used [srb_pkg::MAX_DELAYS];
  logic [31:0] tbl_ident [srb_pkg::MAX_DELAYS];
  logic [7:0]  tbl_owner [srb_pkg::MAX_DELAYS];
  logic [31:0] tbl_tmo [srb_pkg::MAX_DELAYS];
  logic        tbl_wait [srb_pkg::MAX_DELAYS];
  logic [31:0] p_next_ident, p_suspend, p_max_left, p_min_left;
  logic        p_max_on, p_min_on;
  logic [31:0] p_cap, p_dark_min;

  srb_pkg::srb_out_t expected_results[$];
  int n_mismatch = 0;
  int n_results = 0;
  int n_notify = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;

  function automatic logic any_waiting();
    for (int i = 0; i < srb_pkg::MAX_DELAYS; i++) if (tbl_wait[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic release_wait(int s);
    if (!tbl_wait[s]) return 1'b0;
    tbl_wait[s] = 1'b0;
    if (!any_waiting() && !p_min_on) begin
      p_max_on = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void barrier_reset();
    for (int i = 0; i < srb_pkg::MAX_DELAYS; i++) begin
      tbl_used[i] = 0; tbl_wait[i] = 0; tbl_ident[i] = 0; tbl_owner[i] = 0; tbl_tmo[i] = 0;
    end
    p_cap = 10000; p_dark_min = 500; p_next_ident = 1; p_suspend = 0;
    p_max_left = 0; p_max_on = 0; p_min_left = 0; p_min_on = 0;
  endfunction

  // Apply one command to the predictor and return the result it should give
  function automatic srb_pkg::srb_out_t barrier_step(srb_pkg::srb_in_t c);
    srb_pkg::srb_out_t r;
    int s;
    logic waiting;
    logic [31:0] longest;
    r = '0;
    s = -1;
    waiting = 0;
    longest = 0;
    case (c.cmd)
      srb_pkg::CMD_REGISTER: begin
        for (int i = 0; i < srb_pkg::MAX_DELAYS; i++) if (!tbl_used[i] && s < 0) s = i;
        if (s < 0) r.status = srb_pkg::ST_FULL;
        else begin
          tbl_used[s] = 1; tbl_wait[s] = 0; tbl_ident[s] = p_next_ident;
          tbl_owner[s] = c.client_id; tbl_tmo[s] = c.timeout_ticks;
          r.assigned_ident = p_next_ident;
          p_next_ident = p_next_ident + 32'd1;
        end
      end
      srb_pkg::CMD_UNREGISTER: begin
        for (int i = 0; i < srb_pkg::MAX_DELAYS; i++)
          if (s < 0 && tbl_used[i] && tbl_ident[i] == c.dly_ident) s = i;
        if (s < 0) r.status = srb_pkg::ST_UNKNOWN;
        else begin
          r.ready_notify = release_wait(s);
          tbl_used[s] = 0;
        end
      end
      srb_pkg::CMD_ACK: begin
        if (c.susp_num != p_suspend) r.status = srb_pkg::ST_WRONG_SUSPEND;
        else begin
          for (int i = 0; i < srb_pkg::MAX_DELAYS; i++)
            if (s < 0 && tbl_used[i] && tbl_wait[i] && tbl_ident[i] == c.dly_ident) s = i;
          if (s < 0) r.status = srb_pkg::ST_NOT_AWAITED;
          else r.ready_notify = release_wait(s);
        end
      end
      srb_pkg::CMD_CLIENT_GONE: begin
        for (int i = 0; i < srb_pkg::MAX_DELAYS; i++)
          if (tbl_used[i] && tbl_owner[i] == c.client_id) begin
            if (release_wait(i)) r.ready_notify = 1;
            tbl_used[i] = 0;
          end
      end
      srb_pkg::CMD_PREPARE: begin
        p_suspend = c.susp_num;
        for (int i = 0; i < srb_pkg::MAX_DELAYS; i++) begin
          tbl_wait[i] = tbl_used[i];
          if (tbl_used[i]) begin
            waiting = 1;
            if (tbl_tmo[i] > longest) longest = tbl_tmo[i];
          end
        end
        if (c.dark_resume) begin
          p_min_on = 1; p_min_left = p_dark_min;
        end else if (!waiting) r.ready_notify = 1;
        if (waiting) begin
          if (longest > p_cap) longest = p_cap;
          p_max_on = 1; p_max_left = longest;
        end
      end
      srb_pkg::CMD_FINISH: begin
        if (c.susp_num != p_suspend) r.status = srb_pkg::ST_WRONG_SUSPEND;
        else begin
          p_max_on = 0; p_min_on = 0;
          for (int i = 0; i < srb_pkg::MAX_DELAYS; i++) tbl_wait[i] = 0;
        end
      end
      srb_pkg::CMD_TICK: begin
        if (p_min_on) begin
          if (p_min_left <= 1) begin
            p_min_left = 0; p_min_on = 0;
            if (!any_waiting()) begin
              p_max_on = 0; r.ready_notify = 1;
            end
          end else p_min_left = p_min_left - 32'd1;
        end
        if (p_max_on) begin
          if (p_max_left <= 1) begin
            p_max_left = 0; p_max_on = 0;
            for (int i = 0; i < srb_pkg::MAX_DELAYS; i++) tbl_wait[i] = 0;
            r.ready_notify = 1;
          end else p_max_left = p_max_left - 32'd1;
        end
      end
      default: ;
    endcase
    r.ready_susp_num = p_suspend;
    r.ready_now = !any_waiting() && !p_min_on;
    return r;
  endfunction

  // Result check: every strobe must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (out_item.ready_notify) n_notify++;
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", out_item);
      end else begin
        srb_pkg::srb_out_t e;
        e = expected_results.pop_front();
        if (e.ready_notify !== out_item.ready_notify ||
            e.ready_susp_num !== out_item.ready_susp_num ||
            e.assigned_ident !== out_item.assigned_ident ||
            e.status !== out_item.status || e.ready_now !== out_item.ready_now) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p got %p", e, out_item);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("suspend_readiness_barrier_top_tb NOT OK");
      $finish;
    end
  end

  // Issue one command; start stays high after the transfer until the next
  // idle cycle or drain, so it is assigned once per edge
  task automatic send_cmd(srb_pkg::srb_in_t c, logic check_typed = 0,
                          srb_pkg::srb_out_t typed = '0);
    srb_pkg::srb_out_t e;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = barrier_step(c);
    if (check_typed && e !== typed) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("predictor disagrees with table: %p vs %p", e, typed);
    end
    expected_results = {expected_results, e};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      srb_pkg::CFG_MAX_WAIT: p_cap = v;
      srb_pkg::CFG_DARK_MIN: p_dark_min = v;
      srb_pkg::CFG_FIRST_ID: p_next_ident = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic srb_pkg::srb_in_t mk(logic [2:0] cmd, logic [31:0] did, logic [31:0] tmo,
                                          logic [7:0] cli, logic [31:0] sid, logic dark);
    srb_pkg::srb_in_t c;
    c.cmd = cmd; c.dly_ident = did; c.timeout_ticks = tmo;
    c.client_id = cli; c.susp_num = sid; c.dark_resume = dark;
    return c;
  endfunction

  function automatic srb_pkg::srb_out_t res(logic n, logic [31:0] sid, logic [31:0] aid,
                                            logic [2:0] st, logic rn);
    srb_pkg::srb_out_t r;
    r.ready_notify = n; r.ready_susp_num = sid; r.assigned_ident = aid;
    r.status = st; r.ready_now = rn;
    return r;
  endfunction

  // Random command, biased toward live identifiers and the current suspend
  function automatic srb_pkg::srb_in_t rand_cmd();
    srb_pkg::srb_in_t c;
    int k;
    c = mk(3'($urandom_range(7)), $urandom, 32'($urandom_range(9)),
           8'($urandom_range(3)), p_suspend, 1'($urandom_range(1)));
    k = $urandom_range(99);
    if (k < 20) c.cmd = srb_pkg::CMD_REGISTER;
    else if (k < 50) c.cmd = srb_pkg::CMD_TICK;
    else if (k < 60) c.cmd = srb_pkg::CMD_PREPARE;
    if ($urandom_range(9) < 7) c.dly_ident = p_next_ident - 32'd1 - $urandom_range(5);
    if ($urandom_range(9) == 0) c.timeout_ticks = $urandom;
    if ($urandom_range(9) == 0) c.client_id = 8'($urandom);
    if ($urandom_range(9) == 0) c.susp_num = $urandom;
    if (c.cmd == srb_pkg::CMD_PREPARE && $urandom_range(1)) c.susp_num = p_suspend + 32'd1;
    return c;
  endfunction

  srb_pkg::srb_in_t  dir_in  [20];
  srb_pkg::srb_out_t dir_out [20];
  logic     dir_typed [20];
  int n_items;

  initial begin
    barrier_reset();
    // Directed table: typed results where they are evident
    dir_in[0] = mk(srb_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    dir_out[0] = res(0, 0, 0, srb_pkg::ST_OK, 1); dir_typed[0] = 1;
    dir_in[1] = mk(srb_pkg::CMD_UNREGISTER, 32'hFFFF_FFFF, 0, 0, 0, 0);
    dir_out[1] = res(0, 0, 0, srb_pkg::ST_UNKNOWN, 1); dir_typed[1] = 1;
    dir_in[2] = mk(srb_pkg::CMD_PREPARE, 0, 0, 0, 7, 0);
    dir_out[2] = res(1, 7, 0, srb_pkg::ST_OK, 1); dir_typed[2] = 1;
    dir_in[3] = mk(srb_pkg::CMD_FINISH, 0, 0, 0, 8, 0);
    dir_out[3] = res(0, 7, 0, srb_pkg::ST_WRONG_SUSPEND, 1); dir_typed[3] = 1;
    dir_in[4] = mk(srb_pkg::CMD_ACK, 0, 0, 0, 32'hFFFF_FFFF, 1);
    dir_out[4] = res(0, 7, 0, srb_pkg::ST_WRONG_SUSPEND, 1); dir_typed[4] = 1;
    dir_in[5] = mk(srb_pkg::CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                   32'hFFFF_FFFF, 1);
    dir_out[5] = res(0, 7, 0, srb_pkg::ST_OK, 1); dir_typed[5] = 1;
    dir_in[6] = mk(srb_pkg::CMD_REGISTER, 0, 32'hFFFF_FFFF, 8'hFF, 0, 0);
    dir_out[6] = res(0, 7, 1, srb_pkg::ST_OK, 1); dir_typed[6] = 1;
    dir_in[7] = mk(srb_pkg::CMD_REGISTER, 0, 0, 8'h00, 0, 0);
    dir_out[7] = res(0, 7, 2, srb_pkg::ST_OK, 1); dir_typed[7] = 1;
    dir_in[8] = mk(srb_pkg::CMD_PREPARE, 0, 0, 0, 9, 1);  dir_typed[8] = 0;
    dir_in[9] = mk(srb_pkg::CMD_ACK, 1, 0, 0, 9, 0);      dir_typed[9] = 0;
    dir_in[10] = mk(srb_pkg::CMD_ACK, 1, 0, 0, 9, 0);     dir_typed[10] = 0;
    dir_in[11] = mk(srb_pkg::CMD_CLIENT_GONE, 0, 0, 8'h00, 0, 0); dir_typed[11] = 0;
    dir_in[12] = mk(srb_pkg::CMD_TICK, 0, 0, 0, 0, 0);    dir_typed[12] = 0;
    dir_in[13] = mk(srb_pkg::CMD_TICK, 0, 0, 0, 0, 0);    dir_typed[13] = 0;
    dir_in[14] = mk(srb_pkg::CMD_FINISH, 0, 0, 0, 9, 0);  dir_typed[14] = 0;
    dir_in[15] = mk(srb_pkg::CMD_CLIENT_GONE, 0, 0, 8'hFF, 0, 0); dir_typed[15] = 0;
    dir_in[16] = mk(srb_pkg::CMD_REGISTER, 0, 3, 8'h55, 0, 0); dir_typed[16] = 0;
    dir_in[17] = mk(srb_pkg::CMD_PREPARE, 0, 0, 0, 10, 0); dir_typed[17] = 0;
    dir_in[18] = mk(srb_pkg::CMD_UNREGISTER, 3, 0, 0, 0, 0); dir_typed[18] = 0;
    dir_in[19] = mk(srb_pkg::CMD_UNREGISTER, 3, 0, 0, 0, 0); dir_typed[19] = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_in[i]) send_cmd(dir_in[i], dir_typed[i], dir_out[i]);
    drain();

    // Fill the table past full with small timeouts and a small cap
    write_reg(srb_pkg::CFG_MAX_WAIT, 3);
    write_reg(srb_pkg::CFG_DARK_MIN, 0);
    for (int i = 0; i < 18; i++)
      send_cmd(mk(srb_pkg::CMD_REGISTER, 0, i, 8'(i[1:0]), 0, 0));
    send_cmd(mk(srb_pkg::CMD_PREPARE, 0, 0, 0, 11, 1));
    repeat (4) send_cmd(mk(srb_pkg::CMD_TICK, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_cmd(mk(srb_pkg::CMD_CLIENT_GONE, 0, 0, 8'(i), 0, 0));
    drain();

    // Random phases over several register settings, including identifier wrap
    n_items = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(srb_pkg::CFG_MAX_WAIT, 5); write_reg(srb_pkg::CFG_DARK_MIN, 1);
                 write_reg(srb_pkg::CFG_FIRST_ID, 32'hFFFF_FFF8); end
        1: begin write_reg(srb_pkg::CFG_MAX_WAIT, 32'hFFFF_FFFF);
                 write_reg(srb_pkg::CFG_DARK_MIN, 4); end
        2: begin write_reg(srb_pkg::CFG_MAX_WAIT, 0);
                 write_reg(srb_pkg::CFG_DARK_MIN, 32'hFFFF_FFFF);
                 write_reg(srb_pkg::CFG_FIRST_ID, 0); end
        3: begin write_reg(srb_pkg::CFG_MAX_WAIT, 8); write_reg(srb_pkg::CFG_DARK_MIN, 2); end
        4: begin write_reg(srb_pkg::CFG_MAX_WAIT, 1); write_reg(srb_pkg::CFG_DARK_MIN, 6);
                 write_reg(srb_pkg::CFG_FIRST_ID, 32'h8000_0000); end
        default: begin write_reg(srb_pkg::CFG_MAX_WAIT, 6);
                       write_reg(srb_pkg::CFG_DARK_MIN, 3); end
      endcase
      sender_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 61 : 0;
      for (int i = 0; i < 250; i++) begin
        send_cmd(rand_cmd());
        n_items++;
      end
      // Finish the current suspend so the next phase starts clean
      send_cmd(mk(srb_pkg::CMD_FINISH, 0, 0, 0, p_suspend, 0));
      drain();
    end

    $display("covered %0d random commands over six register settings", n_items);
    $display("%0d results checked, %0d with ready notification", n_results, n_notify);
    if (n_mismatch == 0) $display("suspend_readiness_barrier_top_tb OK");
    else $display("suspend_readiness_barrier_top_tb NOT OK");
    $finish;
  end
endmodule
